// ===== design/nsf_pkg.sv =====
// Shared types, character codes and helpers for the NMEA sentence framer.
`timescale 1ns / 1ps

package nsf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 12;
  localparam int unsigned KindW = 3;

  localparam logic [LenW-1:0] MaxLenReset = LenW'(2500);
  localparam logic [LenW-1:0] MinCkLen    = LenW'(3);

  localparam logic [ByteW-1:0] ChBang   = 8'h21;
  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChCr     = 8'h0d;
  localparam logic [ByteW-1:0] ChLf     = 8'h0a;
  localparam logic [ByteW-1:0] ChStar   = 8'h2a;

  localparam logic [KindW-1:0] KindContent  = 3'd0;
  localparam logic [KindW-1:0] KindAccept   = 3'd1;
  localparam logic [KindW-1:0] KindMismatch = 3'd2;
  localparam logic [KindW-1:0] KindTooLong  = 3'd3;
  localparam logic [KindW-1:0] KindNoLf     = 3'd4;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] out_byte;
    logic             first_byte;
    logic [LenW-1:0]  sentence_length;
    logic             had_checksum;
  } result_t;

  // Returns {is_hex, nibble}; the nibble is zero for a non-hex character.
  function automatic logic [4:0] hex_nibble(input logic [ByteW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== design/nsf_framer.sv =====
// Sentence framing state machine, running checksum and verdict logic.
`timescale 1ns / 1ps

module nsf_framer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [nsf_pkg::ByteW-1:0]    byte_i,
  input  logic [nsf_pkg::LenW-1:0]     max_len_i,
  output nsf_pkg::result_t             res_o
);
  import nsf_pkg::*;

  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhContent = 2'd1;
  localparam logic [1:0] PhWaitLf  = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic [LenW-1:0]  count_q, count_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] r0_q, r0_d, r1_q, r1_d, r2_q, r2_d;

  logic [LenW-1:0]  count_inc;
  logic [ByteW-1:0] sum;
  logic [4:0]       hi, lo;
  logic [ByteW-1:0] given;
  result_t          res;

  assign count_inc = count_q + LenW'(1);
  assign sum       = xor_q ^ r0_q ^ r1_q ^ r2_q;
  assign hi        = hex_nibble(r1_q);
  assign lo        = hex_nibble(r0_q);
  assign given     = (hi[4] && lo[4]) ? {hi[3:0], lo[3:0]} : '0;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    xor_d   = xor_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    r2_d    = r2_q;
    res     = '0;
    case (phase_q)
      PhContent: begin
        if (byte_i == ChCr) begin
          phase_d = PhWaitLf;
        end else begin
          count_d             = count_inc;
          xor_d               = xor_q ^ byte_i;
          r0_d                = byte_i;
          r1_d                = r0_q;
          r2_d                = r1_q;
          res.valid           = 1'b1;
          res.sentence_length = count_inc;
          if (count_inc >= max_len_i) begin
            phase_d  = PhIdle;
            res.kind = KindTooLong;
          end else begin
            res.kind     = KindContent;
            res.out_byte = byte_i;
          end
        end
      end
      PhWaitLf: begin
        phase_d             = PhIdle;
        res.valid           = 1'b1;
        res.sentence_length = count_q;
        if (byte_i != ChLf) begin
          res.kind = KindNoLf;
        end else if (count_q >= MinCkLen && r2_q == ChStar) begin
          res.had_checksum = 1'b1;
          res.kind         = (sum == given) ? KindAccept : KindMismatch;
        end else begin
          res.kind = KindAccept;
        end
      end
      default: begin
        phase_d = PhIdle;
        if (byte_i == ChBang || byte_i == ChDollar) begin
          phase_d             = PhContent;
          count_d             = LenW'(1);
          xor_d               = '0;
          r0_d                = byte_i;
          r1_d                = '0;
          r2_d                = '0;
          res.valid           = 1'b1;
          res.kind            = KindContent;
          res.out_byte        = byte_i;
          res.first_byte      = 1'b1;
          res.sentence_length = LenW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      count_q <= '0;
      xor_q   <= '0;
      r0_q    <= '0;
      r1_q    <= '0;
      r2_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      xor_q   <= xor_d;
      r0_q    <= r0_d;
      r1_q    <= r1_d;
      r2_q    <= r2_d;
    end
  end

  assign res_o = res;

endmodule

// ===== design/nmea_sentence_framer.sv =====
// Top level of the NMEA sentence framer: input, result and limit registers.
//
//  Channel  Direction  Handshake                  Word
//  in       input      in_valid_i / in_ready_o    rx_byte_i
//  out      output     out_valid_o / out_ready_i  kind, out_byte, first_byte, length, had_ck
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_max_sentence_length_i
//
// One byte is accepted per cycle while the input register can advance; its result is then registered.
// The framer state is updated as a word leaves the input register.
// A stalled output holds the input register only when that byte produces a result.
// Reset returns to waiting for a start character with a length limit of 2500.
`timescale 1ns / 1ps

module nmea_sentence_framer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [nsf_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [nsf_pkg::KindW-1:0]   kind_o,
  output logic [nsf_pkg::ByteW-1:0]   out_byte_o,
  output logic                        first_byte_o,
  output logic [nsf_pkg::LenW-1:0]    sentence_length_o,
  output logic                        had_checksum_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [nsf_pkg::LenW-1:0]    cfg_max_sentence_length_i
);
  import nsf_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic [LenW-1:0]  max_len_q;
  logic             out_valid_q;
  result_t          out_q;
  result_t          res;
  logic             out_free;
  logic             advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!res.valid || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  nsf_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_max_sentence_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign out_byte_o        = out_q.out_byte;
  assign first_byte_o      = out_q.first_byte;
  assign sentence_length_o = out_q.sentence_length;
  assign had_checksum_o    = out_q.had_checksum;

endmodule
